FILE: src/nmea_sentence_checker_macros.svh
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define NSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nmea_sentence_checker: same-cycle check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define NSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nmea_sentence_checker: next-cycle check failed");

`endif

FILE: src/nsc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Character codes, status codes, the tracker-to-judge bundle and hex decode.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Framing characters.
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Sentence positions that hold the three type characters.
  localparam logic [6:0] POS_TYPE0 = 7'd3;
  localparam logic [6:0] POS_TYPE1 = 7'd4;
  localparam logic [6:0] POS_TYPE2 = 7'd5;

  // Shortest sentence that still has a full header.
  localparam logic [6:0] MIN_HDR_LEN = 7'd7;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_CSUM  = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;

  // Marker for a character that is not a hex digit.
  localparam logic [4:0] HEX_INVALID = 5'd16;

  // Everything the tracker knows about the sentence after the current byte.
  typedef struct packed {
    logic        done;
    logic        any_star;
    logic [1:0]  after_star;
    logic [7:0]  hex_hi;
    logic [7:0]  hex_lo;
    logic [23:0] type_chars;
    logic [6:0]  length;
    logic [7:0]  xor_sum;
  } sentence_t;

  // Hex digit value 0..15, upper or lower case; HEX_INVALID otherwise.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_INVALID;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

FILE: src/nsc_track.sv
// ----------------------------------------------------------------------------
// NMEA sentence tracker
// Holds the per-sentence state and updates it with one byte per step.
// ----------------------------------------------------------------------------
module nsc_track
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 82
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] rx_byte,
  output sentence_t info
);

  localparam logic [6:0] LIMIT = 7'(MAX_LEN + 2);

  logic        in_sent_r, in_sent_nxt;
  logic [6:0]  count_r, count_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        first_star_r, first_star_nxt;
  logic        any_star_r, any_star_nxt;
  logic [1:0]  after_r, after_nxt;
  logic [7:0]  hex_hi_r, hex_hi_nxt;
  logic [7:0]  hex_lo_r, hex_lo_nxt;
  logic [23:0] type_r, type_nxt;

  // Updated view of the sentence before any end-of-sentence clearing.
  logic [6:0]  count_upd;
  logic [7:0]  xor_upd;
  logic        first_star_upd;
  logic        any_star_upd;
  logic [1:0]  after_upd;
  logic [7:0]  hex_hi_upd;
  logic [7:0]  hex_lo_upd;
  logic [23:0] type_upd;
  logic        done;

  // Byte update inside an open sentence.
  always_comb begin
    count_upd      = count_r + 7'd1;
    xor_upd        = xor_r;
    first_star_upd = first_star_r;
    any_star_upd   = any_star_r;
    after_upd      = after_r;
    hex_hi_upd     = hex_hi_r;
    hex_lo_upd     = hex_lo_r;
    type_upd       = type_r;

    if (rx_byte == CH_STAR) begin
      first_star_upd = 1'b1;
      any_star_upd   = 1'b1;
      after_upd      = 2'd0;
    end else begin
      if (!first_star_r) begin
        xor_upd = xor_r ^ rx_byte;
      end
      if (any_star_r) begin
        if (after_r == 2'd0) begin
          hex_hi_upd = rx_byte;
          after_upd  = 2'd1;
        end else if (after_r == 2'd1) begin
          hex_lo_upd = rx_byte;
          after_upd  = 2'd2;
        end
      end
    end

    // Capture the three type characters.
    if (count_r == POS_TYPE0) begin
      type_upd[23:16] = rx_byte;
    end else if (count_r == POS_TYPE1) begin
      type_upd[15:8] = rx_byte;
    end else if (count_r == POS_TYPE2) begin
      type_upd[7:0] = rx_byte;
    end

    // The sentence closes on a newline past the first data byte or at the length cap.
    done = in_sent_r &&
           (((count_r >= 7'd2) && (rx_byte == CH_NEWLINE)) || (count_upd >= LIMIT));
  end

  // Next state: open on a dollar sign, advance inside, clear on close.
  always_comb begin
    in_sent_nxt    = in_sent_r;
    count_nxt      = count_r;
    xor_nxt        = xor_r;
    first_star_nxt = first_star_r;
    any_star_nxt   = any_star_r;
    after_nxt      = after_r;
    hex_hi_nxt     = hex_hi_r;
    hex_lo_nxt     = hex_lo_r;
    type_nxt       = type_r;

    if (!in_sent_r) begin
      if (rx_byte == CH_DOLLAR) begin
        in_sent_nxt    = 1'b1;
        count_nxt      = 7'd1;
        xor_nxt        = 8'd0;
        first_star_nxt = 1'b0;
        any_star_nxt   = 1'b0;
        after_nxt      = 2'd0;
        hex_hi_nxt     = 8'd0;
        hex_lo_nxt     = 8'd0;
        type_nxt       = 24'd0;
      end
    end else if (done) begin
      in_sent_nxt    = 1'b0;
      count_nxt      = 7'd0;
      xor_nxt        = 8'd0;
      first_star_nxt = 1'b0;
      any_star_nxt   = 1'b0;
      after_nxt      = 2'd0;
      hex_hi_nxt     = 8'd0;
      hex_lo_nxt     = 8'd0;
      type_nxt       = 24'd0;
    end else begin
      count_nxt      = count_upd;
      xor_nxt        = xor_upd;
      first_star_nxt = first_star_upd;
      any_star_nxt   = any_star_upd;
      after_nxt      = after_upd;
      hex_hi_nxt     = hex_hi_upd;
      hex_lo_nxt     = hex_lo_upd;
      type_nxt       = type_upd;
    end
  end

  // State registers, moved only when a byte is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r    <= 1'b0;
      count_r      <= 7'd0;
      xor_r        <= 8'd0;
      first_star_r <= 1'b0;
      any_star_r   <= 1'b0;
      after_r      <= 2'd0;
      hex_hi_r     <= 8'd0;
      hex_lo_r     <= 8'd0;
      type_r       <= 24'd0;
    end else if (step) begin
      in_sent_r    <= in_sent_nxt;
      count_r      <= count_nxt;
      xor_r        <= xor_nxt;
      first_star_r <= first_star_nxt;
      any_star_r   <= any_star_nxt;
      after_r      <= after_nxt;
      hex_hi_r     <= hex_hi_nxt;
      hex_lo_r     <= hex_lo_nxt;
      type_r       <= type_nxt;
    end
  end

  // Sentence summary as it stands after this byte.
  assign info.done       = done;
  assign info.any_star   = any_star_upd;
  assign info.after_star = after_upd;
  assign info.hex_hi     = hex_hi_upd;
  assign info.hex_lo     = hex_lo_upd;
  assign info.type_chars = type_upd;
  assign info.length     = count_upd;
  assign info.xor_sum    = xor_upd;

endmodule

FILE: src/nsc_judge.sv
// ----------------------------------------------------------------------------
// NMEA sentence judge
// Decodes the received checksum and picks the status of a closed sentence.
// ----------------------------------------------------------------------------
module nsc_judge
  import nsc_pkg::*;
(
  input  sentence_t  info,
  output logic [2:0] status,
  output logic [7:0] csum_rx
);

  logic [4:0] hi_val;
  logic [4:0] lo_val;
  logic [7:0] value;

  assign hi_val = hex_value(info.hex_hi);
  assign lo_val = hex_value(info.hex_lo);
  assign value  = {hi_val[3:0], lo_val[3:0]};

  // Checks in priority order; the received value is shown only for good digits.
  always_comb begin
    csum_rx = 8'd0;
    priority if (!info.any_star || (info.after_star != 2'd2)) begin
      status = ST_NO_CSUM;
    end else if (hi_val[4] || lo_val[4]) begin
      status = ST_BAD_HEX;
    end else begin
      csum_rx = value;
      if (value != info.xor_sum) begin
        status = ST_MISMATCH;
      end else if (info.length < MIN_HDR_LEN) begin
        status = ST_SHORT;
      end else begin
        status = ST_OK;
      end
    end
  end

endmodule

FILE: src/nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA 0183 sentence checker
// Frames sentences from a byte stream and checks their hex checksum.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_rx_byte
// out      output     out_valid, out_stall, out_status, out_sentence_type,
//                     out_sentence_length, out_checksum_computed,
//                     out_checksum_received
//
// One byte per cycle is taken while in_stall is low; the sentence tracker
// state is registered as each byte moves on. A closing byte passes through
// the input register before its result is loaded into the result register.
// Reset is synchronous on rst_n low and returns the block to idle.
// While the result register is full and stalled, the input register holds
// and in_stall rises once it is occupied.
// ----------------------------------------------------------------------------
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 82
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [23:0] out_sentence_type,
  output logic [6:0]  out_sentence_length,
  output logic [7:0]  out_checksum_computed,
  output logic [7:0]  out_checksum_received
);

  `include "nmea_sentence_checker_macros.svh"

  localparam logic [6:0] LIMIT = 7'(MAX_LEN + 2);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        adv;
  logic        in_take;
  sentence_t   info;
  logic [2:0]  status;
  logic [7:0]  csum_rx;

  logic        out_vld_r, out_vld_nxt;
  logic [2:0]  status_r;
  logic [23:0] type_r;
  logic [6:0]  length_r;
  logic [7:0]  csum_calc_r;
  logic [7:0]  csum_rx_r;

  // The held byte moves on whenever the result register can take a transaction.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  nsc_track #(
    .MAX_LEN(MAX_LEN)
  ) u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .info    (info)
  );

  nsc_judge u_judge (
    .info    (info),
    .status  (status),
    .csum_rx (csum_rx)
  );

  // Result register: loads on a closing byte, empties when taken.
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (adv && info.done) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && info.done) begin
      status_r    <= status;
      type_r      <= info.type_chars;
      length_r    <= info.length;
      csum_calc_r <= info.xor_sum;
      csum_rx_r   <= csum_rx;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_status            = status_r;
  assign out_sentence_type     = type_r;
  assign out_sentence_length   = length_r;
  assign out_checksum_computed = csum_calc_r;
  assign out_checksum_received = csum_rx_r;

  // Assertions on the result logic.
  `NSC_ASSERT_NOW(a_ok_matches,
    out_valid && (out_status == ST_OK),
    out_checksum_received == out_checksum_computed && out_sentence_length >= MIN_HDR_LEN)
  `NSC_ASSERT_NOW(a_bad_rx_zero,
    out_valid && (out_status == ST_NO_CSUM || out_status == ST_BAD_HEX),
    out_checksum_received == 8'd0)
  `NSC_ASSERT_NOW(a_len_range,
    out_valid,
    out_sentence_length >= 7'd2 && out_sentence_length <= LIMIT)
  `NSC_ASSERT_NEXT(a_held_stall,
    out_valid && out_stall,
    out_valid && $stable(status_r) && $stable(length_r))

endmodule

FILE: sim/tb_nmea_sentence_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Sends framed, broken and random sentences with idle noise through the byte
// channel while both sides idle at random. A cycle-free tracker of the
// sentence state predicts each result, and a checker compares every result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import nsc_pkg::*;

  localparam int MAX_LEN = 82;
  localparam int SENTENCE_CAP = MAX_LEN + 2;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // How the checksum field of a generated sentence is built.
  typedef enum int {
    CS_GOOD,
    CS_WRONG,
    CS_BAD_DIGIT,
    CS_ONE_DIGIT,
    CS_BARE_STAR,
    CS_NONE
  } csum_style_t;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] stype;
    logic [6:0]  len;
    logic [7:0]  calc;
    logic [7:0]  rcvd;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [23:0] out_sentence_type;
  logic [6:0]  out_sentence_length;
  logic [7:0]  out_checksum_computed;
  logic [7:0]  out_checksum_received;

  // Predicted sentence tracker state.
  logic        trk_open = 1'b0;
  logic [6:0]  trk_len = '0;
  logic [7:0]  trk_xor = '0;
  logic        trk_xor_stop = 1'b0;
  logic        trk_star = 1'b0;
  logic [1:0]  trk_hex_n = '0;
  logic [7:0]  trk_hi = '0;
  logic [7:0]  trk_lo = '0;
  logic [23:0] trk_type = '0;

  verdict_t verdicts_due[$];
  verdict_t want;
  int mismatches = 0;
  int sentence_bytes = 0;
  bit send_gaps = 1'b1;
  bit stall_bursts = 1'b1;
  int hold_off_cycles = 0;
  int stall_run;

  always #1 clk = ~clk;

  nmea_sentence_checker #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_sentence_type    (out_sentence_type),
    .out_sentence_length  (out_sentence_length),
    .out_checksum_computed(out_checksum_computed),
    .out_checksum_received(out_checksum_received)
  );

  // Value of one checksum character; the top bit flags a non-hex character.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b0, c[3:0]};
    end
    // Upper and lower case letters share the low nibble 1..6.
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b0, c[3:0]} + 5'd9;
    end
    return HEX_INVALID;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) begin
      return 8'h30 + 8'(v);
    end
    return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic octet_q_t to_octets(input string s);
    octet_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Printable body without stars; wild_pct percent of bytes are fully random.
  function automatic octet_q_t random_body(input int n, input int wild_pct);
    octet_q_t q;
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < wild_pct) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        c = 8'($urandom_range(32, 126));
        if (c == CH_STAR) c = CH_COMMA;
      end
      q.push_back(c);
    end
    return q;
  endfunction

  function automatic void clear_tracker();
    trk_len = '0;
    trk_xor = '0;
    trk_xor_stop = 1'b0;
    trk_star = 1'b0;
    trk_hex_n = '0;
    trk_hi = '0;
    trk_lo = '0;
    trk_type = '0;
  endfunction

  // Advances the predicted tracker by one accepted byte and queues the
  // verdict when the sentence closes. Returns 0 for a byte dropped while idle.
  function automatic bit track_byte(input logic [7:0] c);
    logic [6:0] pos;
    logic [4:0] hi_v;
    logic [4:0] lo_v;
    verdict_t v;
    if (!trk_open) begin
      if (c == CH_DOLLAR) begin
        clear_tracker();
        trk_open = 1'b1;
        trk_len = 7'd1;
        return 1'b1;
      end
      return 1'b0;
    end
    pos = trk_len;
    trk_len = trk_len + 7'd1;

    // The first star freezes the XOR; every star restarts the hex digits.
    if (c == CH_STAR) begin
      trk_xor_stop = 1'b1;
      trk_star = 1'b1;
      trk_hex_n = 2'd0;
    end else begin
      if (!trk_xor_stop) trk_xor ^= c;
      if (trk_star && trk_hex_n == 2'd0) begin
        trk_hi = c;
        trk_hex_n = 2'd1;
      end else if (trk_star && trk_hex_n == 2'd1) begin
        trk_lo = c;
        trk_hex_n = 2'd2;
      end
    end

    case (pos)
      POS_TYPE0: trk_type[23:16] = c;
      POS_TYPE1: trk_type[15:8] = c;
      POS_TYPE2: trk_type[7:0] = c;
      default: ;
    endcase

    // A newline right after the dollar sign does not close the sentence.
    if ((pos >= 7'd2 && c == CH_NEWLINE) || int'(trk_len) >= SENTENCE_CAP) begin
      v.stype = trk_type;
      v.len = trk_len;
      v.calc = trk_xor;
      v.rcvd = '0;
      hi_v = digit_value(trk_hi);
      lo_v = digit_value(trk_lo);
      if (!trk_star || trk_hex_n < 2'd2) begin
        v.status = ST_NO_CSUM;
      end else if (hi_v[4] || lo_v[4]) begin
        v.status = ST_BAD_HEX;
      end else begin
        v.rcvd = {hi_v[3:0], lo_v[3:0]};
        if (v.rcvd != trk_xor) v.status = ST_MISMATCH;
        else if (trk_len < MIN_HDR_LEN) v.status = ST_SHORT;
        else v.status = ST_OK;
      end
      verdicts_due.push_back(v);
      trk_open = 1'b0;
      clear_tracker();
    end
    return 1'b1;
  endfunction

  // Offers one byte, optionally after an idle burst, and waits for the
  // transaction to be accepted.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (track_byte(c)) sentence_bytes++;
  endtask

  task automatic send_text(input octet_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Wraps a body as dollar sign, body, checksum field and line end.
  task automatic send_framed(input octet_q_t body, input csum_style_t style,
                             input bit lower);
    logic [7:0] sum;
    logic [7:0] bad;
    octet_q_t q;
    sum = '0;
    foreach (body[i]) sum ^= body[i];
    if (style == CS_WRONG) sum ^= 8'($urandom_range(1, 255));
    bad = 8'h47 + 8'($urandom_range(0, 19));
    q = body;
    q.push_front(CH_DOLLAR);
    case (style)
      CS_GOOD, CS_WRONG: begin
        q.push_back(CH_STAR);
        q.push_back(hex_char(sum[7:4], lower));
        q.push_back(hex_char(sum[3:0], lower));
      end
      CS_BAD_DIGIT: begin
        q.push_back(CH_STAR);
        if ($urandom_range(0, 1)) begin
          q.push_back(bad);
          q.push_back(hex_char(sum[3:0], lower));
        end else begin
          q.push_back(hex_char(sum[7:4], lower));
          q.push_back(bad);
        end
      end
      CS_ONE_DIGIT: begin
        q.push_back(CH_STAR);
        q.push_back(hex_char(sum[7:4], lower));
      end
      CS_BARE_STAR: q.push_back(CH_STAR);
      default: ;
    endcase
    if ($urandom_range(0, 1)) q.push_back(CH_CR);
    q.push_back(CH_NEWLINE);
    send_text(q);
  endtask

  // Mostly well-formed sentences with random content, some broken ones,
  // occasional long ones that hit the length limit, and idle noise between.
  task automatic send_random_sentence();
    logic [7:0] c;
    int n;
    csum_style_t style;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_DOLLAR) c = 8'h00;
        send_byte(c);
      end
    end
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 95) : $urandom_range(0, 20);
    if ($urandom_range(0, 9) < 6) style = CS_GOOD;
    else style = csum_style_t'($urandom_range(1, 5));
    send_framed(random_body(n, 8), style, 1'(($urandom_range(0, 1))));
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_well_formed();
    octet_q_t q;
    send_framed(to_octets("GPGGA,123519,4807.038,N"), CS_GOOD, 1'b0);
    send_framed(to_octets("GPRMC,225446,A,4916.45"), CS_GOOD, 1'b1);
    // Exactly seven bytes is the shortest full header.
    send_text(to_octets("$A*41\r\n"));
    // All-ones bytes give an all-ones type and checksum.
    q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_framed(q, CS_GOOD, 1'b0);
    q = {8'h00, 8'h80, 8'h00, 8'h00, 8'h80};
    send_framed(q, CS_GOOD, 1'b1);
  endtask

  task automatic test_checksum_errors();
    send_framed(to_octets("GPGLL,4916.45,N"), CS_NONE, 1'b0);
    send_framed(to_octets("GPGSA,A,3"), CS_BARE_STAR, 1'b0);
    send_framed(to_octets("GPVTG,054.7,T"), CS_ONE_DIGIT, 1'b1);
    send_framed(to_octets("GPGSV,2,1,08"), CS_BAD_DIGIT, 1'b0);
    send_framed(to_octets("GPHDT,274.07,T"), CS_BAD_DIGIT, 1'b1);
    send_framed(to_octets("GPZDA,201530.00"), CS_WRONG, 1'b0);
    send_framed(to_octets("GPBOD,099.3,T"), CS_WRONG, 1'b1);
    // Matching checksums on sentences whose header is too short.
    send_text(to_octets("$*00\n"));
    send_text(to_octets("$A*41\n"));
  endtask

  task automatic test_framing();
    // Bytes outside a sentence are dropped, framing characters included.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_NEWLINE);
    send_byte(CH_STAR);
    // The byte after the dollar sign is data even when it is a newline.
    send_framed(to_octets("\nGPXTE"), CS_GOOD, 1'b0);
    send_text(to_octets("$\n\n"));
    // A star right after the dollar sign stops the XOR at once.
    send_text(to_octets("$*GPZDA*00\r\n"));
    // A later dollar sign is plain data.
    send_framed(to_octets("GP$GA,1"), CS_GOOD, 1'b0);
    // With several stars the digits follow the last one.
    send_text(to_octets("$GPAB*CD*14\r\n"));
  endtask

  task automatic test_length_limit();
    int lens[$];
    lens = {78, 79, 80, 81, 90};
    foreach (lens[i]) send_framed(random_body(lens[i], 0), CS_GOOD, 1'b0);
  endtask

  // The receiver holds off for a long stretch while bytes keep coming, so
  // the block fills up and stalls its input.
  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_off_cycles = 150;
    repeat (6) send_framed(random_body(12, 0), CS_GOOD, 1'b0);
    send_gaps = 1'b1;
    wait_all_results();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      send_random_sentence();
      wait_all_results();
    end
  endtask

  task automatic test_random_traffic();
    int mark;
    mark = sentence_bytes;
    while (sentence_bytes - mark < 110) send_random_sentence();
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_quiet_finish();
    int mark;
    send_gaps = 1'b0;
    stall_bursts = 1'b0;
    mark = sentence_bytes;
    while (sentence_bytes - mark < 150) send_random_sentence();
  endtask

  // Receiver stall: a requested long hold-off, else random bursts.
  always begin
    @(posedge clk);
    if (hold_off_cycles != 0) begin
      out_stall <= 1'b1;
      repeat (hold_off_cycles) @(posedge clk);
      hold_off_cycles = 0;
      out_stall <= 1'b0;
    end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(1, 10);
      out_stall <= 1'b1;
      repeat (stall_run) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d length %0d", out_status,
                   out_sentence_length);
        end
      end else begin
        want = verdicts_due.pop_front();
        if (out_status !== want.status || out_sentence_type !== want.stype ||
            out_sentence_length !== want.len || out_checksum_computed !== want.calc ||
            out_checksum_received !== want.rcvd) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status %0d type %h length %0d xor %h rx %h",
                     want.status, want.stype, want.len, want.calc, want.rcvd);
            $display("          actual   status %0d type %h length %0d xor %h rx %h",
                     out_status, out_sentence_type, out_sentence_length,
                     out_checksum_computed, out_checksum_received);
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_well_formed();
    test_checksum_errors();
    test_framing();
    test_length_limit();
    test_backpressure();
    test_drain_pause();
    test_random_traffic();
    test_quiet_finish();
    wait_all_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/nsc_pkg.sv
src/nsc_track.sv
src/nsc_judge.sv
src/nmea_sentence_checker.sv
sim/tb_nmea_sentence_checker.sv
